@@ rtl/core/vrd_pkg.sv @@
// Shared types, constants and register codes of the vertical run detector.
`default_nettype none

package vrd_pkg;

  localparam int DEF_MAX_WIDTH  = 8192;
  localparam int DEF_MAX_HEIGHT = 8192;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int SIZE_W   = 14;
  localparam int MARGIN_W = 13;
  localparam int MINLEN_W = 14;

  localparam int COLUMN_W    = 13;
  localparam int RUN_START_W = 13;
  localparam int RUN_END_W   = 14;

  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 14'd4160;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 14'd3120;
  localparam logic [MARGIN_W-1:0] RST_MARGIN_LEFT  = 13'd30;
  localparam logic [MARGIN_W-1:0] RST_MARGIN_RIGHT = 13'd30;
  localparam logic [MINLEN_W-1:0] RST_MIN_LENGTH   = 14'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MARGIN_LEFT  = 3'd2,
    REG_MARGIN_RIGHT = 3'd3,
    REG_MIN_LENGTH   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   image_width;
    logic [SIZE_W-1:0]   image_height;
    logic [MARGIN_W-1:0] margin_left;
    logic [MARGIN_W-1:0] margin_right;
    logic [MINLEN_W-1:0] min_length;
  } cfg_regs_t;

  typedef struct packed {
    logic pixel;
    logic in_margin;
    logic last_row;
  } pix_flags_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_fire;
  } stage_status_t;

endpackage

`default_nettype wire

@@ rtl/core/vrd_pix_if.sv @@
// Input pixel channel with valid and ready.
`default_nettype none

interface vrd_pix_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vrd_run_if.sv @@
// Result channel that carries one reported vertical run per item.
`default_nettype none

interface vrd_run_if import vrd_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [COLUMN_W-1:0]    column;
  logic [RUN_START_W-1:0] run_start;
  logic [RUN_END_W-1:0]   run_end;

  modport source (output valid, output column, output run_start, output run_end, input ready);
  modport sink   (input valid, input column, input run_start, input run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vrd_cfg_if.sv @@
// Configuration write channel with register index and data.
`default_nettype none

interface vrd_cfg_if import vrd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vrd_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/vrd_cfg.sv @@
// Configuration register file of the vertical run detector.
`default_nettype none

module vrd_cfg import vrd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  vrd_cfg_if.sink            cfg_ch,
  output cfg_regs_t          regs
);

  cfg_regs_t regs_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.image_width  <= RST_IMAGE_WIDTH;
      regs_r.image_height <= RST_IMAGE_HEIGHT;
      regs_r.margin_left  <= RST_MARGIN_LEFT;
      regs_r.margin_right <= RST_MARGIN_RIGHT;
      regs_r.min_length   <= RST_MIN_LENGTH;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:  regs_r.image_width  <= cfg_ch.data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: regs_r.image_height <= cfg_ch.data[SIZE_W-1:0];
        REG_MARGIN_LEFT:  regs_r.margin_left  <= cfg_ch.data[MARGIN_W-1:0];
        REG_MARGIN_RIGHT: regs_r.margin_right <= cfg_ch.data[MARGIN_W-1:0];
        REG_MIN_LENGTH:   regs_r.min_length   <= cfg_ch.data[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

@@ rtl/core/vrd_raster.sv @@
// Raster position counters, margin decode and the column state clearing pass.
`default_nettype none

module vrd_raster import vrd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  cfg_regs_t                              regs,
  input  wire logic                              accept,
  input  wire logic                              pixel,
  output logic       [$clog2(MAX_WIDTH)-1:0]     col,
  output logic       [$clog2(MAX_HEIGHT)-1:0]    row,
  output logic       [$clog2(MAX_HEIGHT+1)-1:0]  height,
  output pix_flags_t                             flags,
  output logic                                   clr_busy,
  output logic       [$clog2(MAX_WIDTH)-1:0]     clr_addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = ((WW > SIZE_W) ? WW : SIZE_W) + 1;
  localparam int YW    = ((HW > SIZE_W) ? HW : SIZE_W) + 1;

  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             clr_busy_r, clr_busy_nxt;
  logic [COL_W-1:0] clr_addr_r, clr_addr_nxt;

  logic [XW-1:0] img_w_x, w_x, col_x;
  logic [YW-1:0] img_h_y, h_y, row_y;
  logic          last_col, last_row;

  always_comb begin
    img_w_x = XW'(regs.image_width);
    if (img_w_x == '0) begin
      w_x = XW'(1);
    end else if (img_w_x > XW'(MAX_WIDTH)) begin
      w_x = XW'(MAX_WIDTH);
    end else begin
      w_x = img_w_x;
    end

    img_h_y = YW'(regs.image_height);
    if (img_h_y == '0) begin
      h_y = YW'(1);
    end else if (img_h_y > YW'(MAX_HEIGHT)) begin
      h_y = YW'(MAX_HEIGHT);
    end else begin
      h_y = img_h_y;
    end

    col = (XW'(col_cnt_r) >= w_x) ? '0 : col_cnt_r;
    row = (YW'(row_cnt_r) >= h_y) ? '0 : row_cnt_r;
    col_x = XW'(col);
    row_y = YW'(row);

    last_col = (col_x + XW'(1)) >= w_x;
    last_row = (row_y + YW'(1)) >= h_y;

    flags.pixel     = pixel;
    flags.last_row  = last_row;
    flags.in_margin = (col_x >= XW'(regs.margin_left)) &&
                      ((col_x + XW'(regs.margin_right)) < w_x);
    height = h_y[HW-1:0];

    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row + ROW_W'(1);
    end else begin
      col_cnt_nxt = col + COL_W'(1);
      row_cnt_nxt = row;
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
    end
  end

  assign clr_busy = clr_busy_r;
  assign clr_addr = clr_addr_r;

endmodule

`default_nettype wire

@@ rtl/core/vrd_run_eval.sv @@
// Per-column run update stage with write forwarding and the result register.
`default_nettype none

module vrd_run_eval import vrd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire logic       [$clog2(MAX_WIDTH)-1:0]    col,
  input  wire logic       [$clog2(MAX_HEIGHT)-1:0]   row,
  input  wire logic       [$clog2(MAX_HEIGHT+1)-1:0] height,
  input  pix_flags_t                                 flags,
  input  wire logic       [MINLEN_W-1:0]             min_length,
  input  wire logic       [$clog2(MAX_HEIGHT)+0:0]   ram_rdata,
  output logic                                       ram_we,
  output logic            [$clog2(MAX_WIDTH)-1:0]    ram_waddr,
  output logic            [$clog2(MAX_HEIGHT)+0:0]   ram_wdata,
  output stage_status_t                              status,
  vrd_run_if.source                                  out_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int LW    = (HW > MINLEN_W) ? HW : MINLEN_W;

  logic             s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [HW-1:0]    s1_h_r;
  pix_flags_t       s1_flags_r;

  logic             fwd_valid_r;
  logic [COL_W-1:0] fwd_col_r;
  logic [ROW_W:0]   fwd_data_r;

  logic                   out_valid_r;
  logic [COLUMN_W-1:0]    out_column_r;
  logic [RUN_START_W-1:0] out_start_r;
  logic [RUN_END_W-1:0]   out_end_r;

  logic                 s1_fire;
  logic [ROW_W:0]       cur;
  logic                 active, act_new, ends, emit;
  logic [ROW_W-1:0]     start_new;
  logic [HW-1:0]        end_row, start_h, len;
  logic [COL_W+12:0]    col_ext;
  logic [ROW_W+12:0]    start_ext;
  logic [HW+13:0]       end_ext;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_valid_nxt = accept || (s1_valid_r && !s1_fire);

  always_comb begin
    cur = (fwd_valid_r && (fwd_col_r == s1_col_r)) ? fwd_data_r : ram_rdata;
    active    = cur[ROW_W];
    start_new = cur[ROW_W-1:0];
    act_new   = 1'b0;
    ends      = 1'b0;
    end_row   = HW'(s1_row_r);
    if (s1_flags_r.in_margin) begin
      act_new = active;
      if (s1_flags_r.pixel) begin
        if (!active) begin
          act_new   = 1'b1;
          start_new = s1_row_r;
        end
        if (s1_flags_r.last_row) begin
          ends    = 1'b1;
          end_row = s1_h_r;
        end
      end else if (active) begin
        ends = 1'b1;
      end
      if (ends) begin
        act_new = 1'b0;
      end
    end
    start_h = HW'(start_new);
    len     = (end_row >= start_h) ? (end_row - start_h) : '0;
    emit    = ends && (LW'(len) > LW'(min_length));

    col_ext   = {{13{1'b0}}, s1_col_r};
    start_ext = {{13{1'b0}}, start_new};
    end_ext   = {{14{1'b0}}, end_row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_fire) begin
        fwd_valid_r <= 1'b1;
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= col;
      s1_row_r   <= row;
      s1_h_r     <= height;
      s1_flags_r <= flags;
    end
    if (s1_fire) begin
      fwd_col_r    <= s1_col_r;
      fwd_data_r   <= {act_new, start_new};
      out_column_r <= col_ext[COLUMN_W-1:0];
      out_start_r  <= start_ext[RUN_START_W-1:0];
      out_end_r    <= end_ext[RUN_END_W-1:0];
    end
  end

  assign ram_we    = s1_fire;
  assign ram_waddr = s1_col_r;
  assign ram_wdata = {act_new, start_new};

  assign status.s1_valid = s1_valid_r;
  assign status.s1_fire  = s1_fire;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.column    = out_column_r;
  assign out_ch.run_start = out_start_r;
  assign out_ch.run_end   = out_end_r;

endmodule

`default_nettype wire

@@ rtl/core/vertical_run_detector.sv @@
// Top level of the vertical run detector.
`default_nettype none

// Finds vertical runs of set pixels per column in a binary image streamed in
// raster order, one pixel per item, and reports column, first row and the row
// just past the run when a run longer than min_length ends. Pixels are taken
// at one per clock unless the result channel stalls: an item is registered
// together with a read of its column's state from a single-port-read,
// single-port-write RAM, and once the result register can take it, that
// register stage updates the entry and loads the result register; a
// write-forwarding register covers back-to-back hits on the same column.
// After reset the block clears the per-column run flags and accepts no pixel
// during that pass; configuration writes are taken at any time.
module vertical_run_detector import vrd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vrd_cfg_if.sink   cfg_ch,
  vrd_pix_if.sink   in_ch,
  vrd_run_if.source out_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  cfg_regs_t     regs;
  pix_flags_t    flags;
  stage_status_t status;

  logic             accept;
  logic [COL_W-1:0] col, clr_addr, eval_waddr, ram_waddr;
  logic [ROW_W-1:0] row;
  logic [HW-1:0]    height;
  logic             clr_busy, eval_we, ram_we;
  logic [ROW_W:0]   eval_wdata, ram_wdata, ram_rdata;

  assign in_ch.ready = !clr_busy && (!status.s1_valid || status.s1_fire);
  assign accept      = in_ch.valid && in_ch.ready;

  vrd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  vrd_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk      (clk),
    .rst_n    (rst_n),
    .regs     (regs),
    .accept   (accept),
    .pixel    (in_ch.pixel),
    .col      (col),
    .row      (row),
    .height   (height),
    .flags    (flags),
    .clr_busy (clr_busy),
    .clr_addr (clr_addr)
  );

  assign ram_we    = clr_busy || eval_we;
  assign ram_waddr = clr_busy ? clr_addr : eval_waddr;
  assign ram_wdata = clr_busy ? '0 : eval_wdata;

  vrd_ram #(
    .WIDTH (ROW_W + 1),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  vrd_run_eval #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .col        (col),
    .row        (row),
    .height     (height),
    .flags      (flags),
    .min_length (regs.min_length),
    .ram_rdata  (ram_rdata),
    .ram_we     (eval_we),
    .ram_waddr  (eval_waddr),
    .ram_wdata  (eval_wdata),
    .status     (status),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
